// ===== hdl/balu_pkg.sv =====
// shared types and constants for the byte alu with bcd flags
`default_nettype none

package balu_pkg;

  localparam int unsigned DATA_W = 8;

  localparam logic [8:0] BCD_CARRY_LIMIT = 9'd99;
  localparam logic [8:0] BCD_SUB_BIAS = 9'd199;
  localparam logic [8:0] BCD_SUB_LIMIT = 9'd200;
  localparam logic [8:0] BCD_BASE_1 = 9'd100;
  localparam logic [8:0] BCD_BASE_2 = 9'd200;
  localparam logic [8:0] BCD_BASE_3 = 9'd300;
  localparam logic [7:0] TENS_RECIP = 8'd205;
  localparam int unsigned TENS_SHIFT = 11;

  localparam int unsigned STAT_N = 7;
  localparam int unsigned STAT_V = 6;
  localparam int unsigned STAT_Z = 1;
  localparam int unsigned STAT_C = 0;

  typedef enum logic [4:0] {
    OP_ADC        = 5'd0,
    OP_SBC        = 5'd1,
    OP_AND        = 5'd2,
    OP_ORA        = 5'd3,
    OP_EOR        = 5'd4,
    OP_BIT        = 5'd5,
    OP_CMP_ACC    = 5'd6,
    OP_CMP_OTHER  = 5'd7,
    OP_ASL        = 5'd8,
    OP_LSR        = 5'd9,
    OP_ROL        = 5'd10,
    OP_ROR        = 5'd11,
    OP_INC        = 5'd12,
    OP_DEC        = 5'd13,
    OP_LOAD_ACC   = 5'd14,
    OP_LOAD_OTHER = 5'd15,
    OP_FLAG_LOAD  = 5'd16
  } op_t;

  typedef struct packed {
    logic [DATA_W-1:0] acc;
    logic              c;
    logic              z;
    logic              n;
    logic              v;
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] operand;
    logic [DATA_W-1:0] other_register;
    logic              to_accumulator;
    logic              decimal_mode;
  } item_t;

endpackage

`default_nettype wire

// ===== hdl/balu_bcd.sv =====
// packed bcd add and subtract with carry
`default_nettype none

module balu_bcd
  import balu_pkg::*;
(
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic       cin,
  input  wire logic       subtract,
  output logic      [7:0] res,
  output logic            cout
);

  logic [7:0]  a_val;
  logic [7:0]  b_val;
  logic [8:0]  total;
  logic [8:0]  reduced;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  ones;

  always_comb begin
    a_val = {1'b0, a[7:4], 3'b000} + {3'b000, a[7:4], 1'b0} + {4'b0000, a[3:0]};
    b_val = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    if (subtract) begin
      total = {1'b0, a_val} + BCD_SUB_BIAS + {8'd0, cin} - {1'b0, b_val};
      cout  = (total >= BCD_SUB_LIMIT);
    end else begin
      total = {1'b0, a_val} + {1'b0, b_val} + {8'd0, cin};
      cout  = (total > BCD_CARRY_LIMIT);
    end
    // modulo 100, value stays below 400
    if (total >= BCD_BASE_3) begin
      reduced = total - BCD_BASE_3;
    end else if (total >= BCD_BASE_2) begin
      reduced = total - BCD_BASE_2;
    end else if (total >= BCD_BASE_1) begin
      reduced = total - BCD_BASE_1;
    end else begin
      reduced = total;
    end
    rem      = reduced[6:0];
    // divide by ten through the reciprocal
    prod     = {8'd0, rem} * {7'd0, TENS_RECIP};
    tens     = prod[TENS_SHIFT+3:TENS_SHIFT];
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    ones     = rem - tens_x10;
    res      = {tens, ones[3:0]};
  end

endmodule

`default_nettype wire

// ===== hdl/balu_core.sv =====
// operation decode, result byte and next accumulator and flags
`default_nettype none

module balu_core
  import balu_pkg::*;
(
  input  wire item_t        item,
  input  wire state_t       st,
  output state_t            st_next,
  output logic [DATA_W-1:0] result
);

  logic [DATA_W-1:0] target;
  logic [DATA_W-1:0] add_b;
  logic [DATA_W:0]   bin_sum;
  logic [DATA_W-1:0] cmp_reg;
  logic [DATA_W:0]   cmp_diff;
  logic [DATA_W-1:0] bcd_res;
  logic              bcd_c;
  logic              rmw;

  balu_bcd u_bcd (
    .a        (st.acc),
    .b        (item.operand),
    .cin      (st.c),
    .subtract (item.op == OP_SBC),
    .res      (bcd_res),
    .cout     (bcd_c)
  );

  always_comb begin
    target   = item.to_accumulator ? st.acc : item.operand;
    add_b    = (item.op == OP_SBC) ? ~item.operand : item.operand;
    bin_sum  = {1'b0, st.acc} + {1'b0, add_b} + {{DATA_W{1'b0}}, st.c};
    cmp_reg  = (item.op == OP_CMP_OTHER) ? item.other_register : st.acc;
    cmp_diff = {1'b0, cmp_reg} - {1'b0, item.operand};
    st_next  = st;
    result   = '0;
    rmw      = 1'b0;

    unique case (item.op) inside
      OP_ADC, OP_SBC: begin
        if (item.decimal_mode) begin
          st_next.acc = bcd_res;
          st_next.c   = bcd_c;
        end else begin
          st_next.acc = bin_sum[DATA_W-1:0];
          st_next.c   = bin_sum[DATA_W];
          st_next.v   = (st.acc[DATA_W-1] ^ bin_sum[DATA_W-1])
                      & (add_b[DATA_W-1] ^ bin_sum[DATA_W-1]);
        end
        result    = st_next.acc;
        st_next.z = (st_next.acc == '0);
        st_next.n = st_next.acc[DATA_W-1];
      end
      OP_AND, OP_ORA, OP_EOR, OP_LOAD_ACC: begin
        case (item.op)
          OP_AND:  st_next.acc = st.acc & item.operand;
          OP_ORA:  st_next.acc = st.acc | item.operand;
          OP_EOR:  st_next.acc = st.acc ^ item.operand;
          default: st_next.acc = item.operand;
        endcase
        result    = st_next.acc;
        st_next.z = (st_next.acc == '0);
        st_next.n = st_next.acc[DATA_W-1];
      end
      OP_BIT: begin
        result    = st.acc & item.operand;
        st_next.n = item.operand[STAT_N];
        st_next.v = item.operand[STAT_V];
        st_next.z = (result == '0);
      end
      OP_CMP_ACC, OP_CMP_OTHER: begin
        result    = cmp_diff[DATA_W-1:0];
        st_next.c = ~cmp_diff[DATA_W];
        st_next.z = (cmp_reg == item.operand);
        st_next.n = cmp_diff[DATA_W-1];
      end
      OP_ASL: begin
        result    = {target[DATA_W-2:0], 1'b0};
        st_next.c = target[DATA_W-1];
        rmw       = 1'b1;
      end
      OP_LSR: begin
        result    = {1'b0, target[DATA_W-1:1]};
        st_next.c = target[0];
        rmw       = 1'b1;
      end
      OP_ROL: begin
        result    = {target[DATA_W-2:0], st.c};
        st_next.c = target[DATA_W-1];
        rmw       = 1'b1;
      end
      OP_ROR: begin
        result    = {st.c, target[DATA_W-1:1]};
        st_next.c = target[0];
        rmw       = 1'b1;
      end
      OP_INC: begin
        result = target + {{(DATA_W-1){1'b0}}, 1'b1};
        rmw    = 1'b1;
      end
      OP_DEC: begin
        result = target - {{(DATA_W-1){1'b0}}, 1'b1};
        rmw    = 1'b1;
      end
      OP_LOAD_OTHER: begin
        result    = item.operand;
        st_next.z = (item.operand == '0);
        st_next.n = item.operand[DATA_W-1];
      end
      OP_FLAG_LOAD: begin
        result    = item.operand;
        st_next.n = item.operand[STAT_N];
        st_next.v = item.operand[STAT_V];
        st_next.z = item.operand[STAT_Z];
        st_next.c = item.operand[STAT_C];
      end
      default: begin
        result = '0;
      end
    endcase

    if (rmw) begin
      st_next.z = (result == '0);
      st_next.n = result[DATA_W-1];
      if (item.to_accumulator) begin
        st_next.acc = result;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/byte_alu_with_bcd_flags_unit.sv =====
// top level: input register, alu, accumulator and flag state, result register
// an accepted item waits in the input register, then moves to the result register m_tdata when it is free
// throughput: one item per cycle when m_tready allows, one alu pass between the registers
// the accumulator and flags update when an item moves into the result register
// reset clears the accumulator, the flags and both valid bits
`default_nettype none

module byte_alu_with_bcd_flags_unit
  import balu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operand [7:0], other_register [15:8], to_accumulator [16], decimal_mode [17], zero fill
  input  wire logic [23:0] s_tdata,
  // op [4:0]
  input  wire logic [4:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // result [7:0], accumulator_out [15:8], carry_out [16], zero_out [17],
  // negative_out [18], overflow_out [19], zero fill
  output logic      [23:0] m_tdata
);

  item_t             in_item;
  logic              in_valid;
  state_t            st;
  state_t            st_next;
  logic [DATA_W-1:0] alu_result;
  logic              advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  balu_core u_core (
    .item    (in_item),
    .st      (st),
    .st_next (st_next),
    .result  (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op             <= op_t'(s_tuser);
      in_item.operand        <= s_tdata[7:0];
      in_item.other_register <= s_tdata[15:8];
      in_item.to_accumulator <= s_tdata[16];
      in_item.decimal_mode   <= s_tdata[17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        st       <= st_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0000, st_next.v, st_next.n, st_next.z, st_next.c,
                  st_next.acc, alu_result};
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_byte_alu_with_bcd_flags_unit.sv =====
// testbench for the byte alu with bcd flags: directed and random items against a scoreboard
`timescale 1ns / 100ps

module tb_byte_alu_with_bcd_flags_unit;
  import balu_pkg::*;

  localparam logic [4:0] SPARE_OP_LO = 5'd17;
  localparam logic [4:0] SPARE_OP_HI = 5'd31;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] acc;
    logic       c;
    logic       z;
    logic       n;
    logic       v;
  } alu_outcome_t;

  class alu_scoreboard;
    logic [7:0] acc;
    logic c, z, n, v;
    alu_outcome_t outcome_fifo[$];
    int unsigned errors;
    int unsigned noted;
    int unsigned checked;

    function new();
      acc = '0;
      c = 1'b0;
      z = 1'b0;
      n = 1'b0;
      v = 1'b0;
      errors = 0;
      noted = 0;
      checked = 0;
    endfunction

    function int unsigned bcd_worth(logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function logic [7:0] bcd_pack(int unsigned x);
      int unsigned m;
      m = x % 100;
      return {4'(m / 10), 4'(m % 10)};
    endfunction

    function void set_nz(logic [7:0] r);
      z = (r == 8'h00);
      n = r[7];
    endfunction

    function void add_binary(logic [7:0] m);
      logic [8:0] sum;
      logic [7:0] r;
      logic [7:0] sign_mix;
      sum = {1'b0, acc} + {1'b0, m} + {8'd0, c};
      r = sum[7:0];
      sign_mix = (acc ^ r) & (m ^ r);
      v = sign_mix[7];
      c = sum[8];
      acc = r;
      set_nz(r);
    endfunction

    function logic [7:0] compare_bytes(logic [7:0] reg_val, logic [7:0] m);
      logic [7:0] d;
      d = reg_val - m;
      c = (reg_val >= m);
      z = (reg_val == m);
      n = d[7];
      return d;
    endfunction

    function void note_input(logic [4:0] op, logic [7:0] m, logic [7:0] other,
                             logic to_acc, logic dec);
      logic [7:0] target;
      logic [7:0] r;
      logic cin;
      int unsigned total;
      bit rmw;
      alu_outcome_t o;
      target = to_acc ? acc : m;
      r = 8'h00;
      rmw = 1'b0;
      cin = c;
      case (op)
        OP_ADC: begin
          if (dec) begin
            total = bcd_worth(acc) + bcd_worth(m) + int'(c);
            c = (total > 99);
            acc = bcd_pack(total);
            set_nz(acc);
          end else begin
            add_binary(m);
          end
          r = acc;
        end
        OP_SBC: begin
          if (dec) begin
            // bias of 200 keeps the difference non-negative
            total = bcd_worth(acc) + 200 + int'(c) - 1 - bcd_worth(m);
            c = (total >= 200);
            acc = bcd_pack(total);
            set_nz(acc);
          end else begin
            add_binary(~m);
          end
          r = acc;
        end
        OP_AND: begin
          acc = acc & m;
          set_nz(acc);
          r = acc;
        end
        OP_ORA: begin
          acc = acc | m;
          set_nz(acc);
          r = acc;
        end
        OP_EOR: begin
          acc = acc ^ m;
          set_nz(acc);
          r = acc;
        end
        OP_BIT: begin
          r = acc & m;
          n = m[7];
          v = m[6];
          z = (r == 8'h00);
        end
        OP_CMP_ACC: r = compare_bytes(acc, m);
        OP_CMP_OTHER: r = compare_bytes(other, m);
        OP_ASL: begin
          c = target[7];
          r = {target[6:0], 1'b0};
          rmw = 1'b1;
        end
        OP_LSR: begin
          c = target[0];
          r = {1'b0, target[7:1]};
          rmw = 1'b1;
        end
        OP_ROL: begin
          c = target[7];
          r = {target[6:0], cin};
          rmw = 1'b1;
        end
        OP_ROR: begin
          c = target[0];
          r = {cin, target[7:1]};
          rmw = 1'b1;
        end
        OP_INC: begin
          r = target + 8'd1;
          rmw = 1'b1;
        end
        OP_DEC: begin
          r = target - 8'd1;
          rmw = 1'b1;
        end
        OP_LOAD_ACC: begin
          acc = m;
          set_nz(m);
          r = m;
        end
        OP_LOAD_OTHER: begin
          set_nz(m);
          r = m;
        end
        OP_FLAG_LOAD: begin
          n = m[STAT_N];
          v = m[STAT_V];
          z = m[STAT_Z];
          c = m[STAT_C];
          r = m;
        end
        default: r = 8'h00;
      endcase
      if (rmw) begin
        set_nz(r);
        if (to_acc) acc = r;
      end
      o.result = r;
      o.acc = acc;
      o.c = c;
      o.z = z;
      o.n = n;
      o.v = v;
      outcome_fifo.push_back(o);
      noted++;
    endfunction

    task report_mismatch(string field, int unsigned want, int unsigned got);
      if (errors < PRINT_CAP)
        $display("mismatch on %s at result %0d: expected %0h, got %0h",
                 field, checked, want, got);
      errors++;
    endtask

    task check_result(logic [23:0] word);
      alu_outcome_t want;
      if (outcome_fifo.size() == 0) begin
        report_mismatch("unexpected item", 0, word);
        return;
      end
      want = outcome_fifo.pop_front();
      checked++;
      if (word[7:0] !== want.result) report_mismatch("result", want.result, word[7:0]);
      if (word[15:8] !== want.acc) report_mismatch("accumulator_out", want.acc, word[15:8]);
      if (word[16] !== want.c) report_mismatch("carry_out", want.c, word[16]);
      if (word[17] !== want.z) report_mismatch("zero_out", want.z, word[17]);
      if (word[18] !== want.n) report_mismatch("negative_out", want.n, word[18]);
      if (word[19] !== want.v) report_mismatch("overflow_out", want.v, word[19]);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // operand [7:0], other_register [15:8], to_accumulator [16], decimal_mode [17], zero fill
  logic [23:0] s_tdata;
  // op [4:0]
  logic [4:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // result [7:0], accumulator_out [15:8], carry_out [16], zero_out [17],
  // negative_out [18], overflow_out [19], zero fill
  logic [23:0] m_tdata;

  alu_scoreboard sb;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_req;
  int unsigned stall_cycles;

  byte_alu_with_bcd_flags_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] random_bcd();
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  task automatic send_item(logic [4:0] op, logic [7:0] m, logic [7:0] other,
                           logic to_acc, logic dec);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'd0, dec, to_acc, other, m};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, m, other, to_acc, dec);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic run_random(int unsigned count);
    logic [4:0] op;
    logic [7:0] m;
    logic dec;
    repeat (count) begin
      if ($urandom_range(99) < 3) op = 5'($urandom_range(SPARE_OP_HI, SPARE_OP_LO));
      else op = 5'($urandom_range(OP_FLAG_LOAD, OP_ADC));
      dec = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: m = 8'h00;
        1: m = 8'hff;
        2: m = $urandom_range(1) ? 8'h80 : 8'h7f;
        default: m = 8'($urandom);
      endcase
      if ((op == OP_ADC || op == OP_SBC) && dec) begin
        // mostly well-formed bcd, sometimes with the accumulator loaded as bcd first
        if ($urandom_range(99) < 85) m = random_bcd();
        if ($urandom_range(1))
          send_item(OP_LOAD_ACC, random_bcd(), 8'($urandom), 1'($urandom_range(1)), 1'b0);
      end
      send_item(op, m, 8'($urandom), 1'($urandom_range(1)), dec);
    end
  endtask

  // result side, with one long hold-off when asked
  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    hold_req <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_LOAD_ACC, 8'h00, 8'h00, 1'b0, 1'b0);
    send_item(OP_LOAD_ACC, 8'h50, 8'hff, 1'b1, 1'b1);
    send_item(OP_ADC, 8'h50, 8'h00, 1'b0, 1'b0);
    send_item(OP_SBC, 8'hff, 8'h00, 1'b0, 1'b0);
    send_item(OP_FLAG_LOAD, 8'hff, 8'h00, 1'b0, 1'b0);
    send_item(OP_FLAG_LOAD, 8'h00, 8'h00, 1'b0, 1'b0);
    send_item(OP_LOAD_ACC, 8'h99, 8'h00, 1'b0, 1'b0);
    // decimal carry above 99, then borrow below zero
    send_item(OP_ADC, 8'h01, 8'h00, 1'b0, 1'b1);
    send_item(OP_SBC, 8'h01, 8'h00, 1'b0, 1'b1);
    send_item(OP_SBC, 8'h99, 8'h00, 1'b0, 1'b1);
    // bcd digits above nine
    send_item(OP_ADC, 8'hff, 8'h00, 1'b0, 1'b1);
    send_item(OP_SBC, 8'hfa, 8'h00, 1'b0, 1'b1);
    send_item(OP_AND, 8'h0f, 8'h00, 1'b0, 1'b0);
    send_item(OP_ORA, 8'hf0, 8'h00, 1'b0, 1'b0);
    send_item(OP_EOR, 8'hff, 8'h00, 1'b0, 1'b0);
    send_item(OP_BIT, 8'hc0, 8'h00, 1'b0, 1'b0);
    send_item(OP_CMP_ACC, 8'h00, 8'h00, 1'b0, 1'b0);
    send_item(OP_CMP_ACC, 8'hff, 8'h00, 1'b0, 1'b0);
    send_item(OP_CMP_OTHER, 8'h00, 8'hff, 1'b0, 1'b0);
    send_item(OP_CMP_OTHER, 8'h5a, 8'h5a, 1'b0, 1'b0);
    send_item(OP_ASL, 8'h80, 8'h00, 1'b1, 1'b0);
    send_item(OP_LSR, 8'h01, 8'h00, 1'b0, 1'b0);
    send_item(OP_ROL, 8'h80, 8'h00, 1'b1, 1'b0);
    send_item(OP_ROR, 8'h01, 8'h00, 1'b0, 1'b1);
    send_item(OP_INC, 8'hff, 8'h00, 1'b0, 1'b0);
    send_item(OP_DEC, 8'h00, 8'h00, 1'b1, 1'b0);
    send_item(OP_LOAD_OTHER, 8'h80, 8'h00, 1'b0, 1'b0);
    send_item(SPARE_OP_LO, 8'h55, 8'haa, 1'b0, 1'b0);
    send_item(SPARE_OP_HI, 8'hff, 8'hff, 1'b1, 1'b1);

    tx_idle_pct = 35;
    rx_idle_pct = 55;
    run_random(380);
    tx_idle_pct = 55;
    rx_idle_pct = 35;
    run_random(380);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 1'b1;
    run_random(390);
    s_tvalid <= 1'b0;

    while (sb.outcome_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: all ops, spare codes, binary and bcd, three handshake mixes",
             sb.noted);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
